// File: sv/sine_voice_bank_mixer_macros.svh
// assertion macros for the sine voice bank mixer
// used by the top level only, no other dependencies
`ifndef SINE_VOICE_BANK_MIXER_MACROS_SVH
`define SINE_VOICE_BANK_MIXER_MACROS_SVH

// same-cycle implication
`define SVBM_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("svbm assertion failed");

// next-cycle implication
`define SVBM_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("svbm assertion failed");

`endif

// File: sv/svbm_pkg.sv
// shared constants, types and the sine table for the voice bank mixer
// no dependencies
`timescale 1ns / 1ps

package svbm_pkg;

  localparam int VOICES     = 26;
  localparam int SINE_BITS  = 10;
  localparam int SINE_SIZE  = 1 << SINE_BITS;
  localparam int QUARTER    = SINE_SIZE / 4;

  localparam int CMD_W      = 3;
  localparam int VOICE_W    = 5;
  localparam int STEP_W     = 32;
  localparam int AMP_W      = 16;
  localparam int SAMPLE_W   = 16;

  localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W      = $clog2(VOICES + 1);
  localparam int PROD_W     = SAMPLE_W + AMP_W + 1;
  localparam int ACC_W      = PROD_W + VIDX_W;
  localparam int RND_SHIFT  = 15;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_SET     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_KEY_ON  = 3'd3,
    CMD_KEY_OFF = 3'd4
  } cmd_t;

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_SIZE];

  // quarter-wave value by taylor series in q30, evaluated at elaboration
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] outv;
    x    = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    outv = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (outv > 64'd32767) begin
      outv = 64'd32767;
    end
    return outv[15:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    int quad;
    int r;
    logic signed [SAMPLE_W-1:0] v;
    for (int i = 0; i < SINE_SIZE; i++) begin
      quad = i / QUARTER;
      r    = i % QUARTER;
      v    = (quad % 2 == 1) ? $signed(quarter_sine(QUARTER - r))
                             : $signed(quarter_sine(r));
      rom[i] = (quad >= 2) ? -v : v;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// File: sv/svbm_item_if.sv
// input channel: command items for the voice bank
// depends on svbm_pkg
`timescale 1ns / 1ps

interface svbm_item_if;
  logic                         valid;
  logic                         ready;
  logic [svbm_pkg::CMD_W-1:0]   command;
  logic [svbm_pkg::VOICE_W-1:0] voice;
  logic [svbm_pkg::STEP_W-1:0]  phase_step;
  logic [svbm_pkg::AMP_W-1:0]   amplitude;

  modport source (output valid, command, voice, phase_step, amplitude, input ready);
  modport sink   (input valid, command, voice, phase_step, amplitude, output ready);
endinterface

// File: sv/svbm_result_if.sv
// output channel: mixed samples from the voice bank
// depends on svbm_pkg
`timescale 1ns / 1ps

interface svbm_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [svbm_pkg::SAMPLE_W-1:0] sample;
  logic                                clipped;

  modport source (output valid, sample, clipped, input ready);
  modport sink   (input valid, sample, clipped, output ready);
endinterface

// File: sv/sine_voice_bank_mixer.sv
// top level of the additive sine voice bank with mono mixer
// depends on svbm_pkg, svbm_item_if, svbm_result_if and the macros header
//
//  channel  role    carries
//  item     sink    command, voice, phase_step, amplitude
//  result   source  sample, clipped (one per tick)
//
// a command other than tick is taken while idle and leaves the block ready for the next item
// a tick walks the voice memory one voice a cycle, through the single read port of the
// voice memory and a five-stage datapath
// reset clears the key-on flags, the per-voice written bits and the counter; no clearing pass
// a finished sample waits in the output register; commands are taken meanwhile, and
// a following tick holds at its end until that sample has been transferred
`timescale 1ns / 1ps
`include "sine_voice_bank_mixer_macros.svh"

module sine_voice_bank_mixer (
  input  logic          clk,
  input  logic          rst,
  svbm_item_if.sink     item,
  svbm_result_if.source result
);

  localparam int MEM_W = svbm_pkg::STEP_W + svbm_pkg::AMP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  logic [MEM_W-1:0]                  voice_mem [svbm_pkg::VOICES];
  logic [svbm_pkg::VOICES-1:0]       active_q;
  logic [svbm_pkg::VOICES-1:0]       written_q;
  logic [31:0]                       sample_count;

  logic [svbm_pkg::CNT_W-1:0]        issue_cnt;
  logic [svbm_pkg::VIDX_W-1:0]       issue_idx;
  logic                              last_issue;

  logic [6:0]                        voice_ext;
  logic [svbm_pkg::VIDX_W-1:0]       widx;
  logic                              voice_ok;
  logic                              in_xfer;
  logic                              tick_xfer;
  logic                              mem_we;
  logic [MEM_W-1:0]                  mem_wdata;

  logic                              s1_valid, s2_valid, s3_valid, s4_valid;
  logic                              s1_active, s1_written;
  logic [MEM_W-1:0]                  s1_data;
  logic [svbm_pkg::STEP_W-1:0]       s1_step;
  logic [svbm_pkg::AMP_W-1:0]        s1_level;
  logic [31:0]                       s2_phase;
  logic [svbm_pkg::AMP_W-1:0]        s2_level, s3_level;
  logic signed [svbm_pkg::SAMPLE_W-1:0] s3_sine;
  logic signed [svbm_pkg::PROD_W-1:0] s4_prod;
  logic signed [svbm_pkg::ACC_W-1:0] acc;
  logic                              pipe_busy;

  logic signed [svbm_pkg::ACC_W:0]   rnd_sum;
  logic signed [svbm_pkg::ACC_W:0]   mixed;
  logic                              clip_hi, clip_lo;
  logic signed [svbm_pkg::SAMPLE_W-1:0] sample_next;

  assign item.ready = (state == ST_IDLE);
  assign in_xfer    = item.valid && item.ready;
  assign tick_xfer  = in_xfer && (item.command == svbm_pkg::CMD_TICK);

  assign voice_ext = 7'(item.voice);
  assign widx      = voice_ext[svbm_pkg::VIDX_W-1:0];
  assign voice_ok  = 32'(item.voice) < 32'(svbm_pkg::VOICES);

  assign mem_we    = in_xfer && voice_ok &&
                     (item.command == svbm_pkg::CMD_SET || item.command == svbm_pkg::CMD_CLEAR);
  assign mem_wdata = (item.command == svbm_pkg::CMD_SET) ? {item.phase_step, item.amplitude}
                                                         : '0;

  assign issue_idx  = issue_cnt[svbm_pkg::VIDX_W-1:0];
  assign last_issue = (issue_cnt == svbm_pkg::CNT_W'(svbm_pkg::VOICES - 1));
  assign pipe_busy  = s1_valid || s2_valid || s3_valid || s4_valid;

  // voice memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      voice_mem[widx] <= mem_wdata;
    end
    s1_data <= voice_mem[issue_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_q     <= '0;
      written_q    <= '0;
      sample_count <= '0;
    end else begin
      if (mem_we) begin
        written_q[widx] <= 1'b1;
      end
      if (in_xfer && voice_ok) begin
        case (item.command)
          svbm_pkg::CMD_KEY_ON:  active_q[widx] <= 1'b1;
          svbm_pkg::CMD_KEY_OFF: active_q[widx] <= 1'b0;
          default: ;
        endcase
      end
      if (tick_xfer) begin
        sample_count <= sample_count + 32'd1;
      end
    end
  end

  // unwritten entries read as zero
  assign s1_step  = s1_written ? s1_data[MEM_W-1 -: svbm_pkg::STEP_W] : '0;
  assign s1_level = (s1_written && s1_active) ? s1_data[svbm_pkg::AMP_W-1:0] : '0;

  always_ff @(posedge clk) begin
    s1_active  <= active_q[issue_idx];
    s1_written <= written_q[issue_idx];
    s2_phase   <= 32'(s1_step * sample_count);
    s2_level   <= s1_level;
    s3_sine    <= svbm_pkg::SINE_ROM[s2_phase[31 -: svbm_pkg::SINE_BITS]];
    s3_level   <= s2_level;
    s4_prod    <= svbm_pkg::PROD_W'(s3_sine * $signed({1'b0, s3_level}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_WALK);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      acc <= '0;
    end else if (s4_valid) begin
      acc <= acc + svbm_pkg::ACC_W'(s4_prod);
    end
  end

  // round once to q1.15 and saturate
  assign rnd_sum     = (svbm_pkg::ACC_W + 1)'(acc) +
                       (svbm_pkg::ACC_W + 1)'(1 << (svbm_pkg::RND_SHIFT - 1));
  assign mixed       = rnd_sum >>> svbm_pkg::RND_SHIFT;
  assign clip_hi     = mixed > (svbm_pkg::ACC_W + 1)'(32767);
  assign clip_lo     = mixed < -(svbm_pkg::ACC_W + 1)'(32768);
  assign sample_next = clip_hi ? 16'sh7fff :
                       clip_lo ? 16'sh8000 : mixed[svbm_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      issue_cnt      <= '0;
      result.valid   <= 1'b0;
      result.sample  <= '0;
      result.clipped <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != ST_EMIT) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tick_xfer) begin
            issue_cnt <= '0;
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          issue_cnt <= issue_cnt + svbm_pkg::CNT_W'(1);
          if (last_issue) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid   <= 1'b1;
            result.sample  <= sample_next;
            result.clipped <= clip_hi || clip_lo;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SVBM_ASSERT_NEXT(a_count_step, clk, rst, tick_xfer, sample_count == $past(sample_count) + 32'd1)
  `SVBM_ASSERT_NOW(a_idle_pipe_empty, clk, rst, state == ST_IDLE, !pipe_busy)
  `SVBM_ASSERT_NOW(a_clip_at_rail, clk, rst, result.valid && result.clipped, result.sample == 16'sh7fff || result.sample == 16'sh8000)

endmodule

// File: tb/tb_sine_voice_bank_mixer.sv
// self-checking testbench for the sine voice bank mixer: directed and random command traffic
// predicts each mixed sample from its own voice bank and sine table and checks every transfer
// depends on svbm_pkg, svbm_item_if, svbm_result_if and sine_voice_bank_mixer
`timescale 1ns / 1ps

module tb_sine_voice_bank_mixer;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int VOICE_MAX      = (1 << svbm_pkg::VOICE_W) - 1;
  localparam logic [svbm_pkg::CMD_W-1:0] CMD_HIGHEST = '1;

  typedef struct {
    logic signed [svbm_pkg::SAMPLE_W-1:0] sample;
    logic                                 clipped;
  } mix_result_t;

  logic clk;
  logic rst;

  svbm_item_if   item_bus();
  svbm_result_if sample_bus();

  sine_voice_bank_mixer uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (sample_bus)
  );

  logic signed [svbm_pkg::SAMPLE_W-1:0] sine_lut [svbm_pkg::SINE_SIZE];
  logic [svbm_pkg::STEP_W-1:0]          tuning_words [svbm_pkg::VOICES];
  logic [svbm_pkg::AMP_W-1:0]           gains [svbm_pkg::VOICES];
  logic                                 keyed [svbm_pkg::VOICES];
  logic [31:0]                          tick_count;

  mix_result_t expected_mixes [$];
  int          mismatches;
  int          idle_cycles;
  bit          steady;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // quarter-wave sine in q30 via taylor series
  function automatic int quarter_wave(input int unsigned k);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint          sum;
    longint          val;
    angle    = (64'd1686629713 * 64'(k)) / 64'(svbm_pkg::QUARTER);
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    sum      = longint'(angle);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    val = (sum * 32767 + (64'sd1 << 29)) >>> 30;
    if (val > 32767) begin
      val = 32767;
    end
    return int'(val);
  endfunction

  function automatic void build_sine_lut();
    int quad;
    int r;
    int v;
    for (int i = 0; i < svbm_pkg::SINE_SIZE; i++) begin
      quad = i / svbm_pkg::QUARTER;
      r    = i % svbm_pkg::QUARTER;
      v    = (quad % 2 == 1) ? quarter_wave(svbm_pkg::QUARTER - r) : quarter_wave(r);
      sine_lut[i] = (quad >= 2) ? svbm_pkg::SAMPLE_W'(-v) : svbm_pkg::SAMPLE_W'(v);
    end
  endfunction

  function automatic void clear_bank();
    for (int v = 0; v < svbm_pkg::VOICES; v++) begin
      tuning_words[v] = '0;
      gains[v]        = '0;
      keyed[v]        = 1'b0;
    end
    tick_count = '0;
  endfunction

  // counter advances first, then every keyed voice adds its scaled table value
  function automatic mix_result_t predict_mix();
    mix_result_t                    r;
    longint                         acc;
    longint                         rounded;
    logic [31:0]                    phase;
    logic [svbm_pkg::SINE_BITS-1:0] idx;
    tick_count = tick_count + 32'd1;
    acc = 0;
    for (int v = 0; v < svbm_pkg::VOICES; v++) begin
      if (keyed[v]) begin
        phase = tuning_words[v] * tick_count;
        idx   = phase[31 -: svbm_pkg::SINE_BITS];
        acc   = acc + longint'(sine_lut[idx]) * longint'(gains[v]);
      end
    end
    rounded   = (acc + 64'sd16384) >>> 15;
    r.clipped = 1'b0;
    if (rounded > 32767) begin
      rounded   = 32767;
      r.clipped = 1'b1;
    end else if (rounded < -32768) begin
      rounded   = -32768;
      r.clipped = 1'b1;
    end
    r.sample = svbm_pkg::SAMPLE_W'(rounded);
    return r;
  endfunction

  function automatic void apply_command(input logic [svbm_pkg::CMD_W-1:0] cmd,
                                        input logic [svbm_pkg::VOICE_W-1:0] voice,
                                        input logic [svbm_pkg::STEP_W-1:0] step,
                                        input logic [svbm_pkg::AMP_W-1:0] amp);
    if (cmd == svbm_pkg::CMD_TICK) begin
      expected_mixes.push_back(predict_mix());
    end else if (voice < svbm_pkg::VOICES) begin
      case (cmd)
        svbm_pkg::CMD_SET: begin
          tuning_words[voice] = step;
          gains[voice]        = amp;
        end
        svbm_pkg::CMD_CLEAR: begin
          tuning_words[voice] = '0;
          gains[voice]        = '0;
        end
        svbm_pkg::CMD_KEY_ON: begin
          keyed[voice] = 1'b1;
        end
        svbm_pkg::CMD_KEY_OFF: begin
          keyed[voice] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [svbm_pkg::CMD_W-1:0] cmd,
                           input logic [svbm_pkg::VOICE_W-1:0] voice,
                           input logic [svbm_pkg::STEP_W-1:0] step,
                           input logic [svbm_pkg::AMP_W-1:0] amp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.command    <= cmd;
    item_bus.voice      <= voice;
    item_bus.phase_step <= step;
    item_bus.amplitude  <= amp;
    do @(posedge clk); while (!item_bus.ready);
    apply_command(cmd, voice, step, amp);
  endtask

  // unused fields carry random values
  task automatic send_tick();
    send_item(svbm_pkg::CMD_TICK, svbm_pkg::VOICE_W'($urandom), $urandom,
              svbm_pkg::AMP_W'($urandom));
  endtask

  function automatic logic [svbm_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return svbm_pkg::STEP_W'($urandom_range(0, 1 << 20));
      1:       return svbm_pkg::STEP_W'($urandom_range(0, svbm_pkg::SINE_SIZE - 1))
                      << (32 - svbm_pkg::SINE_BITS);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [svbm_pkg::AMP_W-1:0] pick_amp();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return svbm_pkg::AMP_W'($urandom_range(16'h7000, 16'h9000));
      2:       return svbm_pkg::AMP_W'($urandom_range(0, 255));
      default: return svbm_pkg::AMP_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_silence();
    send_tick();
    send_tick();
  endtask

  task automatic test_directed_voices();
    logic [svbm_pkg::VOICE_W-1:0] top_voice;
    top_voice = svbm_pkg::VOICE_W'(svbm_pkg::VOICES - 1);
    send_item(svbm_pkg::CMD_SET, '0, 32'h4000_0000, 16'h8000);
    send_tick();
    send_item(svbm_pkg::CMD_KEY_ON, '0, '0, '0);
    send_item(svbm_pkg::CMD_SET, top_voice, 32'h4000_0000, 16'hFFFF);
    send_item(svbm_pkg::CMD_KEY_ON, top_voice, '0, '0);
    repeat (4) send_tick();
    send_item(svbm_pkg::CMD_CLEAR, top_voice, '1, '1);
    send_tick();
    send_item(svbm_pkg::CMD_SET, top_voice, 32'hFFFF_FFFF, 16'h7FFF);
    send_tick();
    send_item(svbm_pkg::CMD_SET, svbm_pkg::VOICE_W'(svbm_pkg::VOICES), 32'h1234_5678,
              16'hFFFF);
    send_item(svbm_pkg::CMD_KEY_ON, svbm_pkg::VOICE_W'(VOICE_MAX), '0, '0);
    for (int c = svbm_pkg::CMD_KEY_OFF + 1; c <= CMD_HIGHEST; c++) begin
      send_item(svbm_pkg::CMD_W'(c), svbm_pkg::VOICE_W'($urandom), $urandom,
                svbm_pkg::AMP_W'($urandom));
    end
    send_tick();
    send_item(svbm_pkg::CMD_KEY_OFF, '0, '0, '0);
    send_item(svbm_pkg::CMD_KEY_OFF, top_voice, '0, '0);
    send_tick();
  endtask

  // every voice keyed at high gain, so the mix saturates often
  task automatic test_full_bank();
    for (int v = 0; v < svbm_pkg::VOICES; v++) begin
      send_item(svbm_pkg::CMD_SET, svbm_pkg::VOICE_W'(v), pick_step(),
                svbm_pkg::AMP_W'($urandom_range(16'hC000, 16'hFFFF)));
      send_item(svbm_pkg::CMD_KEY_ON, svbm_pkg::VOICE_W'(v), '0, '0);
    end
    repeat (20) send_tick();
    for (int v = 0; v < svbm_pkg::VOICES; v += 2) begin
      send_item(svbm_pkg::CMD_KEY_OFF, svbm_pkg::VOICE_W'(v), '0, '0);
    end
    repeat (6) send_tick();
  endtask

  task automatic test_random_traffic(input int n_items);
    int counted;
    int roll;
    logic [svbm_pkg::VOICE_W-1:0] voice;
    counted = 0;
    while (counted < n_items) begin
      if (counted % 100 == 0) begin
        steady = ($urandom_range(0, 4) == 0);
      end
      roll  = $urandom_range(0, 99);
      voice = svbm_pkg::VOICE_W'($urandom_range(0, svbm_pkg::VOICES - 1));
      if (roll < 40) begin
        send_tick();
        counted++;
      end else if (roll < 60) begin
        send_item(svbm_pkg::CMD_SET, voice, pick_step(), pick_amp());
        counted++;
      end else if (roll < 73) begin
        send_item(svbm_pkg::CMD_KEY_ON, voice, $urandom, svbm_pkg::AMP_W'($urandom));
        counted++;
      end else if (roll < 83) begin
        send_item(svbm_pkg::CMD_KEY_OFF, voice, $urandom, svbm_pkg::AMP_W'($urandom));
        counted++;
      end else if (roll < 90) begin
        send_item(svbm_pkg::CMD_CLEAR, voice, $urandom, svbm_pkg::AMP_W'($urandom));
        counted++;
      end else if (roll < 95) begin
        send_item(svbm_pkg::CMD_W'($urandom_range(svbm_pkg::CMD_SET, svbm_pkg::CMD_KEY_OFF)),
                  svbm_pkg::VOICE_W'($urandom_range(svbm_pkg::VOICES, VOICE_MAX)),
                  $urandom, svbm_pkg::AMP_W'($urandom));
      end else begin
        send_item(svbm_pkg::CMD_W'($urandom_range(svbm_pkg::CMD_KEY_OFF + 1, CMD_HIGHEST)),
                  svbm_pkg::VOICE_W'($urandom), $urandom, svbm_pkg::AMP_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.command    <= svbm_pkg::CMD_TICK;
    item_bus.voice      <= '0;
    item_bus.phase_step <= '0;
    item_bus.amplitude  <= '0;
    mismatches = 0;
    steady     = 1'b0;
    build_sine_lut();
    clear_bank();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_silence();
    test_directed_voices();
    test_full_bank();
    test_random_traffic(1380);
    item_bus.valid <= 1'b0;
    wait (expected_mixes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_mixes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : sample_sink
    int stall;
    sample_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        sample_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sample_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_samples
    mix_result_t want;
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      if (expected_mixes.size() == 0) begin
        $error("sample transfer with nothing expected: sample %0d clipped %0b",
               sample_bus.sample, sample_bus.clipped);
        mismatches++;
      end else begin
        want = expected_mixes.pop_front();
        if (sample_bus.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, sample_bus.sample);
          mismatches++;
        end
        if (sample_bus.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, sample_bus.clipped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (sample_bus.valid && sample_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: sine_voice_bank_mixer.f
+incdir+sv
sv/svbm_pkg.sv
sv/svbm_item_if.sv
sv/svbm_result_if.sv
sv/sine_voice_bank_mixer.sv
tb/tb_sine_voice_bank_mixer.sv
